// File: hw/rtl/fpfa_pkg.sv
// Package for the fixed-partition fit allocator.
// Holds field widths, request/status/policy codes, the scan control struct
// and width helpers shared by the cell row and the top level.
package fpfa_pkg;

	localparam int unsigned DEF_BLOCKS    = 16;
	localparam int unsigned DEF_SIZE_BITS = 16;

	localparam int unsigned REQ_TYPE_W = 2;
	localparam int unsigned INDEX_W    = 4;
	localparam int unsigned BSIZE_W    = 16;
	localparam int unsigned RSIZE_W    = 16;
	localparam int unsigned STATUS_W   = 2;
	localparam int unsigned GRANT_W    = 4;
	localparam int unsigned NEXT_W     = 4;
	localparam int unsigned POLICY_W   = 2;
	localparam int unsigned COUNT_W    = 5;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 5;

	typedef enum logic [POLICY_W-1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} fit_policy_t;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ALLOC = 2'd1,
		REQ_CLEAR = 2'd2,
		REQ_NOP   = 2'd3
	} req_type_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_GRANT = 2'd1,
		ST_NOFIT = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIT_POLICY  = 1'd0,
		CFG_BLOCK_COUNT = 1'd1
	} cfg_reg_t;

	typedef struct packed {
		logic        valid;
		fit_policy_t policy;
		logic        best_found;
		logic        hi_found;
	} scan_ctl_t;

	function automatic int unsigned idx_width(input int unsigned blocks);
		return (blocks > 1) ? $clog2(blocks) : 1;
	endfunction

	function automatic int unsigned cnt_width(input int unsigned blocks);
		int unsigned w;
		w = $clog2(blocks + 1);
		return (w > COUNT_W) ? w : COUNT_W;
	endfunction

endpackage

// File: hw/rtl/fpfa_if.sv
// Request and response channel interfaces of the fit allocator.
// Depends on fpfa_pkg for the payload widths.
interface fpfa_req_if;
	import fpfa_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [REQ_TYPE_W-1:0] req_type;
	logic [INDEX_W-1:0]    block_index;
	logic [BSIZE_W-1:0]    block_size;
	logic [RSIZE_W-1:0]    request_size;

	modport source(output valid, req_type, block_index, block_size, request_size,
		input ready);
	modport sink(input valid, req_type, block_index, block_size, request_size,
		output ready);
endinterface

interface fpfa_rsp_if;
	import fpfa_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [GRANT_W-1:0]  granted_block;

	modport source(output valid, status, granted_block, input ready);
	modport sink(input valid, status, granted_block, output ready);
endinterface

// File: hw/rtl/fpfa_cell.sv
// One partition cell: holds a size and a taken mark, and refines the
// running scan candidate handed in by its left neighbor. Depends on fpfa_pkg.
module fpfa_cell #(
	parameter int unsigned BLOCKS    = fpfa_pkg::DEF_BLOCKS,
	parameter int unsigned SIZE_BITS = fpfa_pkg::DEF_SIZE_BITS,
	parameter int unsigned CELL_IDX  = 0
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      ld_en,
	input  logic [SIZE_BITS-1:0]                      ld_size,
	input  logic                                      clr,
	input  logic                                      mark,
	input  logic [fpfa_pkg::cnt_width(BLOCKS)-1:0]    n_eff,
	input  fpfa_pkg::scan_ctl_t                       in_ctl,
	input  logic [fpfa_pkg::RSIZE_W-1:0]              in_need,
	input  logic [fpfa_pkg::NEXT_W-1:0]               in_start,
	input  logic [fpfa_pkg::idx_width(BLOCKS)-1:0]    in_best_idx,
	input  logic [SIZE_BITS-1:0]                      in_best_size,
	input  logic [fpfa_pkg::idx_width(BLOCKS)-1:0]    in_hi_idx,
	output fpfa_pkg::scan_ctl_t                       out_ctl,
	output logic [fpfa_pkg::RSIZE_W-1:0]              out_need,
	output logic [fpfa_pkg::NEXT_W-1:0]               out_start,
	output logic [fpfa_pkg::idx_width(BLOCKS)-1:0]    out_best_idx,
	output logic [SIZE_BITS-1:0]                      out_best_size,
	output logic [fpfa_pkg::idx_width(BLOCKS)-1:0]    out_hi_idx,
	output logic                                      taken
);
	import fpfa_pkg::*;

	localparam int unsigned IDX_W = idx_width(BLOCKS);
	localparam int unsigned CNT_W = cnt_width(BLOCKS);
	localparam int unsigned CMP_W = (SIZE_BITS > RSIZE_W) ? SIZE_BITS : RSIZE_W;

	logic [SIZE_BITS-1:0] size_q;
	logic                 taken_q;
	logic                 usable;
	logic                 take_best;
	logic                 take_hi;

	scan_ctl_t            ctl_s1;
	logic [RSIZE_W-1:0]   need_s1;
	logic [NEXT_W-1:0]    start_s1;
	logic [IDX_W-1:0]     best_idx_s1;
	logic [SIZE_BITS-1:0] best_size_s1;
	logic [IDX_W-1:0]     hi_idx_s1;

	always_comb begin
		usable = !taken_q && (CMP_W'(size_q) >= CMP_W'(in_need))
			&& (CNT_W'(CELL_IDX) < n_eff);
		take_best = usable && (!in_ctl.best_found
			|| (in_ctl.policy == FIT_BEST && size_q < in_best_size)
			|| (in_ctl.policy == FIT_WORST && size_q > in_best_size));
		take_hi = usable && !in_ctl.hi_found && (CNT_W'(CELL_IDX) >= CNT_W'(in_start));
	end

	always_ff @(posedge clk) begin
		if (ld_en) begin
			size_q <= ld_size;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taken_q <= 1'b0;
		end else if (ld_en || clr) begin
			taken_q <= 1'b0;
		end else if (mark) begin
			taken_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid      <= in_ctl.valid;
			ctl_s1.policy     <= in_ctl.policy;
			ctl_s1.best_found <= in_ctl.best_found || take_best;
			ctl_s1.hi_found   <= in_ctl.hi_found || take_hi;
		end
	end

	always_ff @(posedge clk) begin
		need_s1      <= in_need;
		start_s1     <= in_start;
		best_idx_s1  <= take_best ? IDX_W'(CELL_IDX) : in_best_idx;
		best_size_s1 <= take_best ? size_q : in_best_size;
		hi_idx_s1    <= take_hi ? IDX_W'(CELL_IDX) : in_hi_idx;
	end

	assign out_ctl       = ctl_s1;
	assign out_need      = need_s1;
	assign out_start     = start_s1;
	assign out_best_idx  = best_idx_s1;
	assign out_best_size = best_size_s1;
	assign out_hi_idx    = hi_idx_s1;
	assign taken         = taken_q;

endmodule

// File: hw/rtl/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator: configuration registers,
// control sequencer, result register and the row of fpfa_cell partition cells.
// Depends on fpfa_pkg and the channel interfaces in fpfa_if.sv.
//
// Usage:
//   req carries load, allocate and clear items; rsp returns one result per item
//   (status, granted_block). A transfer happens when valid and ready are high.
//   cfg_we/cfg_idx/cfg_wdata write fit_policy (index 0) and block_count
//   (index 1); write them only while no item is outstanding.
//   Load, clear and unused request types do not scan: the result is registered
//   straight into the rsp output register when rsp can take it.
//   An allocate runs a candidate down the row of BLOCKS cells, one cell per
//   cycle, and commits the mark on the next edge; the scan length is set by
//   the length of the cell row, independent of block_count.
//   One item is in work at a time; req.ready is high whenever the sequencer is
//   idle, even while an earlier result still waits on rsp.
//   When rsp stalls, a finished result parks in a holding register and
//   req.ready stays low until that result moves to rsp.
//   Reset frees every partition, clears the next-fit pointer, sets first fit
//   and a count of 16; partition sizes are undefined until loaded.
module fixed_partition_fit_allocator #(
	parameter int unsigned BLOCKS    = fpfa_pkg::DEF_BLOCKS,
	parameter int unsigned SIZE_BITS = fpfa_pkg::DEF_SIZE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [fpfa_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fpfa_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	fpfa_req_if.sink                          req,
	fpfa_rsp_if.source                        rsp
);
	import fpfa_pkg::*;

	localparam int unsigned IDX_W = idx_width(BLOCKS);
	localparam int unsigned CNT_W = cnt_width(BLOCKS);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_PEND = 3'b100
	} state_t;

	state_t             state_q;
	fit_policy_t        fit_policy_q;
	logic [COUNT_W-1:0] block_count_q;
	logic [NEXT_W-1:0]  next_start_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [GRANT_W-1:0]  out_grant_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [GRANT_W-1:0]  res_grant_q;

	scan_ctl_t            chain_ctl       [0:BLOCKS];
	logic [RSIZE_W-1:0]   chain_need      [0:BLOCKS];
	logic [NEXT_W-1:0]    chain_start     [0:BLOCKS];
	logic [IDX_W-1:0]     chain_best_idx  [0:BLOCKS];
	logic [SIZE_BITS-1:0] chain_best_size [0:BLOCKS];
	logic [IDX_W-1:0]     chain_hi_idx    [0:BLOCKS];
	logic [BLOCKS-1:0]    taken_vec;
	logic [BLOCKS-1:0]    scan_valid_vec;

	req_type_t           rtype;
	logic                accept;
	logic                out_free;
	logic [CNT_W-1:0]    count_min;
	logic [CNT_W-1:0]    n_eff;
	logic                ld_in_range;
	logic                last_valid;
	logic                found;
	logic [IDX_W-1:0]    got;
	logic [CNT_W-1:0]    got_next;
	logic                new_res;
	logic [STATUS_W-1:0] new_status;
	logic [GRANT_W-1:0]  new_grant;
	logic                scan_busy;

	always_comb begin
		rtype       = req_type_t'(req.req_type);
		accept      = req.valid && req.ready;
		out_free    = !out_valid_q || rsp.ready;
		count_min   = (block_count_q == '0) ? CNT_W'(1) : CNT_W'(block_count_q);
		n_eff       = (count_min > CNT_W'(BLOCKS)) ? CNT_W'(BLOCKS) : count_min;
		ld_in_range = CNT_W'(req.block_index) < n_eff;

		last_valid = chain_ctl[BLOCKS].valid;
		found      = chain_ctl[BLOCKS].best_found;
		got        = (chain_ctl[BLOCKS].policy == FIT_NEXT && chain_ctl[BLOCKS].hi_found)
			? chain_hi_idx[BLOCKS] : chain_best_idx[BLOCKS];
		got_next   = CNT_W'(got) + CNT_W'(1);

		new_res    = last_valid || (accept && rtype != REQ_ALLOC);
		new_status = ST_DONE;
		new_grant  = '0;
		if (last_valid) begin
			new_status = found ? ST_GRANT : ST_NOFIT;
			new_grant  = found ? GRANT_W'(got) : '0;
		end else begin
			case (rtype)
				REQ_LOAD: new_status = ld_in_range ? ST_DONE : ST_RANGE;
				default:  new_status = ST_DONE;
			endcase
		end

		scan_busy = |scan_valid_vec;
	end

	// launch point of the cell row
	always_comb begin
		chain_ctl[0].valid      = accept && rtype == REQ_ALLOC;
		chain_ctl[0].policy     = fit_policy_q;
		chain_ctl[0].best_found = 1'b0;
		chain_ctl[0].hi_found   = 1'b0;
		chain_need[0]           = req.request_size;
		chain_start[0]          = (CNT_W'(next_start_q) < n_eff) ? next_start_q : '0;
		chain_best_idx[0]       = '0;
		chain_best_size[0]      = '0;
		chain_hi_idx[0]         = '0;
	end

	for (genvar g = 0; g < BLOCKS; g++) begin : g_cell
		logic ld_hit;
		logic mark_hit;

		assign ld_hit = accept && rtype == REQ_LOAD && ld_in_range
			&& (CNT_W'(req.block_index) == CNT_W'(g));
		assign mark_hit = last_valid && found && (got == IDX_W'(g));
		assign scan_valid_vec[g] = chain_ctl[g+1].valid;

		fpfa_cell #(
			.BLOCKS   (BLOCKS),
			.SIZE_BITS(SIZE_BITS),
			.CELL_IDX (g)
		) u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ld_en        (ld_hit),
			.ld_size      (SIZE_BITS'(req.block_size)),
			.clr          (accept && rtype == REQ_CLEAR),
			.mark         (mark_hit),
			.n_eff        (n_eff),
			.in_ctl       (chain_ctl[g]),
			.in_need      (chain_need[g]),
			.in_start     (chain_start[g]),
			.in_best_idx  (chain_best_idx[g]),
			.in_best_size (chain_best_size[g]),
			.in_hi_idx    (chain_hi_idx[g]),
			.out_ctl      (chain_ctl[g+1]),
			.out_need     (chain_need[g+1]),
			.out_start    (chain_start[g+1]),
			.out_best_idx (chain_best_idx[g+1]),
			.out_best_size(chain_best_size[g+1]),
			.out_hi_idx   (chain_hi_idx[g+1]),
			.taken        (taken_vec[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_policy_q  <= FIT_FIRST;
			block_count_q <= COUNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_idx))
				CFG_FIT_POLICY:  fit_policy_q  <= fit_policy_t'(cfg_wdata[POLICY_W-1:0]);
				CFG_BLOCK_COUNT: block_count_q <= cfg_wdata[COUNT_W-1:0];
				default:         fit_policy_q  <= fit_policy_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			next_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept && rtype == REQ_CLEAR) begin
				next_start_q <= '0;
			end else if (last_valid && found && chain_ctl[BLOCKS].policy == FIT_NEXT) begin
				next_start_q <= (got_next == n_eff) ? '0 : NEXT_W'(got_next);
			end

			if (new_res && out_free) begin
				out_valid_q <= 1'b1;
			end else if (state_q == S_PEND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (rtype == REQ_ALLOC) begin
							state_q <= S_SCAN;
						end else if (!out_free) begin
							state_q <= S_PEND;
						end
					end
				end
				S_SCAN: begin
					if (last_valid) begin
						state_q <= out_free ? S_IDLE : S_PEND;
					end
				end
				S_PEND: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (new_res && out_free) begin
			out_status_q <= new_status;
			out_grant_q  <= new_grant;
		end else if (state_q == S_PEND && out_free) begin
			out_status_q <= res_status_q;
			out_grant_q  <= res_grant_q;
		end
		if (new_res && !out_free) begin
			res_status_q <= new_status;
			res_grant_q  <= new_grant;
		end
	end

	assign req.ready         = (state_q == S_IDLE);
	assign rsp.valid         = out_valid_q;
	assign rsp.status        = out_status_q;
	assign rsp.granted_block = out_grant_q;

	a_idle_no_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !scan_busy)
		else $error("scan in flight while sequencer idle");

	a_commit_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		last_valid |-> (state_q == S_SCAN))
		else $error("scan result outside scan state");

	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && found) |-> (!taken_vec[got] && CNT_W'(got) < n_eff))
		else $error("granted partition taken or beyond count");

	a_grant_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(last_valid && found) |=> taken_vec[$past(got)])
		else $error("granted partition not marked");

	a_nogrant_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ST_GRANT) |-> (out_grant_q == '0))
		else $error("nonzero block on failed request");

endmodule
